FILE: hdl/flash_ring_slot_mapper_core_macros.svh
// Assertion macros shared by the slot mapper RTL.
// Relies on the including module having signals named clock and reset.
`ifndef FLASH_RING_SLOT_MAPPER_CORE_MACROS_SVH
`define FLASH_RING_SLOT_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FRSM_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("slot mapper assertion failed");

// Next-cycle implication, disabled during reset.
`define FRSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slot mapper assertion failed");

`endif

FILE: hdl/frsm_pkg.sv
// Shared widths, register indexes, the pipeline item type and the divider step.
// No dependencies; used by frsm_div_pipe and flash_ring_slot_mapper_core.
`default_nettype none

package frsm_pkg;

   localparam int ADDR_W      = 32;
   localparam int ID_W        = 32;
   localparam int CNT_W       = 24;
   localparam int SEC_W       = 17;
   localparam int TOT_W       = 9;
   localparam int PAY_W       = 10;
   localparam int BLOCK_W     = 11;
   localparam int N_W         = 26;
   localparam int X_W         = 27;
   localparam int PROD_W      = 28;
   localparam int DIV_W       = 32;
   localparam int DVS_W       = 26;
   localparam int DIV_STAGES  = DIV_W;
   localparam int STEP_W      = $clog2(DIV_STAGES);
   localparam int CSR_IDX_W   = 3;
   localparam int FULL_W      = ID_W + 1;

   localparam int BLOCK_OVERHEAD = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_BYTES  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_TOTAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_BYTES = 3'd3;

   localparam logic [ADDR_W-1:0] RST_REGION_BASE   = 32'd0;
   localparam logic [SEC_W-1:0]  RST_SECTOR_BYTES  = 17'd1024;
   localparam logic [TOT_W-1:0]  RST_SECTOR_TOTAL  = 9'd2;
   localparam logic [PAY_W-1:0]  RST_PAYLOAD_BYTES = 10'd26;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef struct packed {
      logic              vld;
      logic              unset;
      logic              fits;
      logic              below_n;
      logic [ID_W-1:0]   id;
      logic              q_zero;
      logic [N_W-1:0]    off;
      logic [N_W-1:0]    rem;
      logic [X_W-1:0]    x;
      logic [X_W-1:0]    x2;
      logic [PROD_W-1:0] j_s;
      logic [PROD_W-1:0] k_s;
      logic              ovf;
      logic [PROD_W-1:0] lostnum;
      logic [ADDR_W-1:0] slot;
      logic [ADDR_W-1:0] page;
      logic              erase;
   } item_type;

   // One restoring division step: returns {next partial remainder, quotient bit}.
   function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] r,
                                                input logic b,
                                                input logic [DVS_W-1:0] d);
      logic [DVS_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         return {t[DVS_W-1:0], 1'b1};
      end
      return {t[DVS_W-1:0], 1'b0};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/frsm_div_pipe.sv
// Radix-2 pipelined divider, one quotient bit per stage, carrying a pipeline item.
// A second lane shares the divisor and yields only a quotient. Uses frsm_pkg.
`default_nettype none

module frsm_div_pipe (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire frsm_pkg::item_type            in_item,
   input  wire logic [frsm_pkg::DIV_W-1:0]    dividend,
   input  wire logic [frsm_pkg::DIV_W-1:0]    aux_dividend,
   input  wire logic [frsm_pkg::DVS_W-1:0]    divisor,
   output frsm_pkg::item_type                 out_item,
   output logic [frsm_pkg::DIV_W-1:0]         quotient,
   output logic [frsm_pkg::DVS_W-1:0]         remainder,
   output logic [frsm_pkg::DIV_W-1:0]         aux_quotient
);

   frsm_pkg::item_type               item_ff  [frsm_pkg::DIV_STAGES];
   logic [frsm_pkg::DVS_W-1:0]       r_ff     [frsm_pkg::DIV_STAGES];
   logic [frsm_pkg::DIV_W-1:0]       w_ff     [frsm_pkg::DIV_STAGES];
   logic [frsm_pkg::DVS_W-1:0]       ar_ff    [frsm_pkg::DIV_STAGES];
   logic [frsm_pkg::DIV_W-1:0]       aw_ff    [frsm_pkg::DIV_STAGES];

   // The word register shifts the dividend out at the top and the quotient in
   // at the bottom, so after the last stage it holds the quotient.
   for (genvar i = 0; i < frsm_pkg::DIV_STAGES; i++) begin : g_stage
      frsm_pkg::item_type           item_src;
      logic [frsm_pkg::DVS_W-1:0]   r_src;
      logic [frsm_pkg::DIV_W-1:0]   w_src;
      logic [frsm_pkg::DVS_W-1:0]   ar_src;
      logic [frsm_pkg::DIV_W-1:0]   aw_src;
      logic [frsm_pkg::DVS_W:0]     step;
      logic [frsm_pkg::DVS_W:0]     astep;

      if (i == 0) begin : g_first
         assign item_src = in_item;
         assign r_src    = '0;
         assign w_src    = dividend;
         assign ar_src   = '0;
         assign aw_src   = aux_dividend;
      end else begin : g_next
         assign item_src = item_ff[i-1];
         assign r_src    = r_ff[i-1];
         assign w_src    = w_ff[i-1];
         assign ar_src   = ar_ff[i-1];
         assign aw_src   = aw_ff[i-1];
      end

      assign step  = frsm_pkg::div_step(r_src, w_src[frsm_pkg::DIV_W-1], divisor);
      assign astep = frsm_pkg::div_step(ar_src, aw_src[frsm_pkg::DIV_W-1], divisor);

      always_ff @(posedge clock) begin
         if (reset) begin
            item_ff[i].vld <= 1'b0;
         end else if (en) begin
            item_ff[i] <= item_src;
            r_ff[i]    <= step[frsm_pkg::DVS_W:1];
            w_ff[i]    <= {w_src[frsm_pkg::DIV_W-2:0], step[0]};
            ar_ff[i]   <= astep[frsm_pkg::DVS_W:1];
            aw_ff[i]   <= {aw_src[frsm_pkg::DIV_W-2:0], astep[0]};
         end
      end
   end

   assign out_item     = item_ff[frsm_pkg::DIV_STAGES-1];
   assign quotient     = w_ff[frsm_pkg::DIV_STAGES-1];
   assign remainder    = r_ff[frsm_pkg::DIV_STAGES-1];
   assign aux_quotient = aw_ff[frsm_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hdl/flash_ring_slot_mapper_core.sv
// Top level of the cyclic flash log slot mapper: config registers, setup divider,
// and the request pipeline. Uses frsm_pkg, frsm_div_pipe and the macros header.
//
// Usage:
//   A request carries one record id on req_record_id (req_valid/req_ready).
//   Each request yields exactly one response on the rsp_ channel, in order:
//   slot address, readable record count, erase flag, erase page, unset flag.
//   One request can be accepted every cycle while req_ready is high. Requests
//   pass through three 32-stage bit-serial divider pipelines in series
//   (id by slot count, offset by sector size, sector limit by block size)
//   plus the s0_ff to s4_ff register stages and the response register.
//   Registers are written through csr_wr_en/csr_index/csr_wdata while no request
//   is in flight. After reset and after every write the block derives the slot
//   count and the base offset within a sector in its load and run states;
//   req_ready stays low during that time.
//   When the receiver holds rsp_ready low with a response pending, the whole
//   pipeline freezes and nothing is lost or repeated; req_ready follows.
//   Reset is synchronous and active high.
`default_nettype none

`include "flash_ring_slot_mapper_core_macros.svh"

module flash_ring_slot_mapper_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [frsm_pkg::ID_W-1:0]        req_record_id,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [frsm_pkg::ADDR_W-1:0]           rsp_slot_address,
   output logic [frsm_pkg::CNT_W-1:0]            rsp_valid_count,
   output logic                                  rsp_erase_needed,
   output logic [frsm_pkg::ADDR_W-1:0]           rsp_erase_page_address,
   output logic                                  rsp_id_unset,
   input  wire logic                             csr_wr_en,
   input  wire logic [frsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [frsm_pkg::ADDR_W-1:0]      csr_wdata
);

   localparam logic [1:0] CFG_IDLE = 2'd0;
   localparam logic [1:0] CFG_LOAD = 2'd1;
   localparam logic [1:0] CFG_RUN  = 2'd2;

   // Configuration registers
   logic [frsm_pkg::ADDR_W-1:0] region_base_ff;
   logic [frsm_pkg::SEC_W-1:0]  sector_bytes_ff;
   logic [frsm_pkg::TOT_W-1:0]  sector_total_ff;
   logic [frsm_pkg::PAY_W-1:0]  payload_bytes_ff;

   // Setup sequencer
   logic [1:0]                  cfg_state_ff;
   logic [frsm_pkg::STEP_W-1:0] cfg_cnt_ff;
   logic [frsm_pkg::DIV_W-1:0]  nw_ff;
   logic [frsm_pkg::DVS_W-1:0]  nr_ff;
   logic [frsm_pkg::DIV_W-1:0]  bw_ff;
   logic [frsm_pkg::DVS_W-1:0]  bwr_ff;
   logic [frsm_pkg::N_W-1:0]    n_ff;
   logic [frsm_pkg::SEC_W-1:0]  br_ff;

   logic [frsm_pkg::BLOCK_W-1:0] block_w;
   logic [frsm_pkg::DVS_W-1:0]   block_dvs;
   logic [frsm_pkg::DVS_W-1:0]   sec_dvs;
   logic [frsm_pkg::DVS_W-1:0]   total_w;
   logic [frsm_pkg::DVS_W:0]     nstep;
   logic [frsm_pkg::DVS_W:0]     bstep;
   logic [frsm_pkg::DIV_W-1:0]   nw_in;
   logic [frsm_pkg::DIV_W-1:0]   bw_in;

   assign block_w   = frsm_pkg::BLOCK_W'(payload_bytes_ff)
                    + frsm_pkg::BLOCK_W'(frsm_pkg::BLOCK_OVERHEAD);
   assign block_dvs = frsm_pkg::DVS_W'(block_w);
   assign sec_dvs   = frsm_pkg::DVS_W'(sector_bytes_ff);
   assign total_w   = frsm_pkg::DVS_W'(sector_bytes_ff) * frsm_pkg::DVS_W'(sector_total_ff);
   assign nstep     = frsm_pkg::div_step(nr_ff, nw_ff[frsm_pkg::DIV_W-1], block_dvs);
   assign bstep     = frsm_pkg::div_step(bwr_ff, bw_ff[frsm_pkg::DIV_W-1], sec_dvs);
   assign nw_in     = {nw_ff[frsm_pkg::DIV_W-2:0], nstep[0]};
   assign bw_in     = {bw_ff[frsm_pkg::DIV_W-2:0], bstep[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff   <= frsm_pkg::RST_REGION_BASE;
         sector_bytes_ff  <= frsm_pkg::RST_SECTOR_BYTES;
         sector_total_ff  <= frsm_pkg::RST_SECTOR_TOTAL;
         payload_bytes_ff <= frsm_pkg::RST_PAYLOAD_BYTES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            frsm_pkg::CSR_REGION_BASE:   region_base_ff   <= csr_wdata;
            frsm_pkg::CSR_SECTOR_BYTES:  sector_bytes_ff  <= csr_wdata[frsm_pkg::SEC_W-1:0];
            frsm_pkg::CSR_SECTOR_TOTAL:  sector_total_ff  <= csr_wdata[frsm_pkg::TOT_W-1:0];
            frsm_pkg::CSR_PAYLOAD_BYTES: payload_bytes_ff <= csr_wdata[frsm_pkg::PAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Slot count (total / block) and base mod sector size, one bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff <= CFG_LOAD;
         cfg_cnt_ff   <= '0;
      end else if (csr_wr_en) begin
         cfg_state_ff <= CFG_LOAD;
         cfg_cnt_ff   <= '0;
      end else begin
         unique case (cfg_state_ff)
            CFG_LOAD: begin
               nw_ff        <= frsm_pkg::DIV_W'(total_w);
               nr_ff        <= '0;
               bw_ff        <= region_base_ff;
               bwr_ff       <= '0;
               cfg_cnt_ff   <= '0;
               cfg_state_ff <= CFG_RUN;
            end
            CFG_RUN: begin
               nw_ff      <= nw_in;
               nr_ff      <= nstep[frsm_pkg::DVS_W:1];
               bw_ff      <= bw_in;
               bwr_ff     <= bstep[frsm_pkg::DVS_W:1];
               cfg_cnt_ff <= cfg_cnt_ff + frsm_pkg::STEP_W'(1);
               if (cfg_cnt_ff == frsm_pkg::STEP_W'(frsm_pkg::DIV_STAGES - 1)) begin
                  n_ff         <= nw_in[frsm_pkg::N_W-1:0];
                  br_ff        <= bstep[frsm_pkg::SEC_W:1];
                  cfg_state_ff <= CFG_IDLE;
               end
            end
            default: cfg_state_ff <= CFG_IDLE;
         endcase
      end
   end

   // Request pipeline
   logic en;
   logic rsp_valid_ff;

   frsm_pkg::item_type s0_in, s0_ff, a_item, s1_in, s1_ff, s2_in, s2_ff;
   frsm_pkg::item_type b_item, s3_in, s3_ff, s4_in, s4_ff, d_item;

   logic [frsm_pkg::DIV_W-1:0]  a_quot;
   logic [frsm_pkg::DVS_W-1:0]  a_rem;
   logic [frsm_pkg::DIV_W-1:0]  a_aux;
   logic [frsm_pkg::DIV_W-1:0]  b_quot;
   logic [frsm_pkg::DVS_W-1:0]  b_rem;
   logic [frsm_pkg::DIV_W-1:0]  b_aux;
   logic [frsm_pkg::DIV_W-1:0]  d_quot;
   logic [frsm_pkg::DVS_W-1:0]  d_rem;
   logic [frsm_pkg::DIV_W-1:0]  d_aux;
   logic [frsm_pkg::N_W-1:0]    q_inc;
   logic [frsm_pkg::PROD_W-1:0] j_inc;
   logic [frsm_pkg::PROD_W-1:0] k_inc;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && (cfg_state_ff == CFG_IDLE);

   always_comb begin
      s0_in         = '0;
      s0_in.vld     = req_valid && req_ready;
      s0_in.id      = req_record_id;
      s0_in.unset   = &req_record_id;
      s0_in.fits    = (n_ff != '0);
      s0_in.below_n = (frsm_pkg::ID_W'(n_ff) > req_record_id);
   end

   frsm_div_pipe u_div_slot (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_item      (s0_ff),
      .dividend     (s0_ff.id),
      .aux_dividend ('0),
      .divisor      (n_ff),
      .out_item     (a_item),
      .quotient     (a_quot),
      .remainder    (a_rem),
      .aux_quotient (a_aux)
   );

   // a_rem is id mod N; the remainder of id + 1 follows without a second divide.
   assign q_inc = a_rem + frsm_pkg::N_W'(1);

   always_comb begin
      s1_in        = a_item;
      s1_in.off    = a_rem * frsm_pkg::N_W'(block_w);
      s1_in.rem    = (q_inc == n_ff) ? '0 : q_inc;
      s1_in.q_zero = (a_rem == '0);
   end

   always_comb begin
      s2_in    = s1_ff;
      s2_in.x  = frsm_pkg::X_W'(br_ff) + frsm_pkg::X_W'(s1_ff.off);
      s2_in.x2 = frsm_pkg::X_W'(br_ff) + frsm_pkg::X_W'(s1_ff.off)
               + frsm_pkg::X_W'(block_w);
   end

   // Sector of the slot and of the slot end, both relative to the aligned base.
   frsm_div_pipe u_div_sector (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_item      (s2_ff),
      .dividend     (frsm_pkg::DIV_W'(s2_ff.x)),
      .aux_dividend (frsm_pkg::DIV_W'(s2_ff.x2)),
      .divisor      (sec_dvs),
      .out_item     (b_item),
      .quotient     (b_quot),
      .remainder    (b_rem),
      .aux_quotient (b_aux)
   );

   assign j_inc = frsm_pkg::PROD_W'(b_quot) + frsm_pkg::PROD_W'(1);
   assign k_inc = frsm_pkg::PROD_W'(b_aux) + frsm_pkg::PROD_W'(1);

   always_comb begin
      s3_in     = b_item;
      s3_in.j_s = j_inc * frsm_pkg::PROD_W'(sector_bytes_ff);
      s3_in.k_s = k_inc * frsm_pkg::PROD_W'(sector_bytes_ff);
      s3_in.ovf = ({1'b0, b_rem} + (frsm_pkg::DVS_W + 1)'(block_w))
                >= (frsm_pkg::DVS_W + 1)'(sector_bytes_ff);
   end

   always_comb begin
      s4_in         = s3_ff;
      s4_in.lostnum = s3_ff.k_s - frsm_pkg::PROD_W'(br_ff);
      s4_in.slot    = region_base_ff + frsm_pkg::ADDR_W'(s3_ff.off);
      s4_in.erase   = 1'b0;
      s4_in.page    = '0;
      priority if (!s3_ff.fits) begin
         s4_in.slot  = region_base_ff;
         s4_in.erase = 1'b1;
         s4_in.page  = region_base_ff;
      end else if (s3_ff.q_zero) begin
         s4_in.erase = 1'b1;
         s4_in.page  = region_base_ff;
      end else if (s3_ff.ovf) begin
         s4_in.erase = 1'b1;
         s4_in.page  = region_base_ff - frsm_pkg::ADDR_W'(br_ff)
                     + frsm_pkg::ADDR_W'(s3_ff.j_s);
      end
   end

   // Slots up to the end of the sector that holds the slot end.
   frsm_div_pipe u_div_lost (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_item      (s4_ff),
      .dividend     (frsm_pkg::DIV_W'(s4_ff.lostnum)),
      .aux_dividend ('0),
      .divisor      (block_dvs),
      .out_item     (d_item),
      .quotient     (d_quot),
      .remainder    (d_rem),
      .aux_quotient (d_aux)
   );

   logic [frsm_pkg::FULL_W-1:0] gain;
   logic [frsm_pkg::FULL_W-1:0] lost1;
   logic [frsm_pkg::FULL_W-1:0] count_full;
   logic [frsm_pkg::CNT_W-1:0]  count_sat;

   assign gain  = frsm_pkg::FULL_W'(n_ff) + frsm_pkg::FULL_W'(d_item.rem);
   assign lost1 = frsm_pkg::FULL_W'(d_quot) + frsm_pkg::FULL_W'(1);

   always_comb begin
      priority if (d_item.below_n) begin
         count_full = frsm_pkg::FULL_W'(d_item.id) + frsm_pkg::FULL_W'(1);
      end else if (d_item.rem == '0) begin
         count_full = frsm_pkg::FULL_W'(n_ff);
      end else if (sector_total_ff == frsm_pkg::TOT_W'(1)) begin
         count_full = frsm_pkg::FULL_W'(d_item.rem);
      end else if (gain > lost1) begin
         count_full = gain - lost1;
      end else begin
         count_full = '0;
      end
      if (count_full > frsm_pkg::FULL_W'(frsm_pkg::CNT_MAX)) begin
         count_sat = frsm_pkg::CNT_MAX;
      end else begin
         count_sat = count_full[frsm_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld    <= 1'b0;
         s1_ff.vld    <= 1'b0;
         s2_ff.vld    <= 1'b0;
         s3_ff.vld    <= 1'b0;
         s4_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         rsp_valid_ff <= d_item.vld;
         priority if (d_item.unset) begin
            rsp_slot_address       <= '0;
            rsp_valid_count        <= '0;
            rsp_erase_needed       <= 1'b0;
            rsp_erase_page_address <= '0;
            rsp_id_unset           <= 1'b1;
         end else begin
            rsp_slot_address       <= d_item.slot;
            rsp_valid_count        <= d_item.fits ? count_sat : '0;
            rsp_erase_needed       <= d_item.erase;
            rsp_erase_page_address <= d_item.page;
            rsp_id_unset           <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FRSM_ASSERT_NEXT(a_csr_write_blocks_req, csr_wr_en, !req_ready)
   `FRSM_ASSERT_IMPL(a_unset_rsp_zero, rsp_valid && rsp_id_unset, rsp_valid_count == '0 && !rsp_erase_needed && rsp_slot_address == '0)
   `FRSM_ASSERT_IMPL(a_no_erase_no_page, rsp_valid && !rsp_erase_needed, rsp_erase_page_address == '0)

endmodule

`default_nettype wire

FILE: dv/tb_flash_ring_slot_mapper_core.sv
// Testbench for flash_ring_slot_mapper_core: drives record ids through several register
// settings and checks every response against an in-bench slot, count and erase calculation.
// Depends on frsm_pkg and the RTL of the slot mapper.
`timescale 1ns / 100ps

typedef struct {
   logic [31:0] slot_address;
   logic [23:0] valid_count;
   logic        erase_needed;
   logic [31:0] erase_page_address;
   logic        id_unset;
} slot_map_type;

class slot_map_scoreboard;
   longint unsigned region_base, sector_bytes, sector_total, payload_bytes;
   slot_map_type    expected_q[$];
   int              mismatch_count;

   function new();
      region_base   = 0;
      sector_bytes  = 1024;
      sector_total  = 2;
      payload_bytes = 26;
      mismatch_count = 0;
   endfunction

   function longint unsigned slot_count();
      return (sector_bytes * sector_total) / (payload_bytes + frsm_pkg::BLOCK_OVERHEAD);
   endfunction

   function slot_map_type map_id(logic [31:0] record_id);
      slot_map_type    r;
      longint unsigned block, n, slot, m, rem, cnt, page, lim, lost, nxt;
      block = payload_bytes + frsm_pkg::BLOCK_OVERHEAD;
      n = slot_count();
      r = '{default: 0};
      if (record_id == 32'hFFFF_FFFF) begin
         r.id_unset = 1'b1;
         return r;
      end
      if (n == 0) begin
         r.slot_address = region_base[31:0];
         r.erase_needed = 1'b1;
         r.erase_page_address = region_base[31:0];
         return r;
      end
      slot = region_base + (longint'(record_id) % n) * block;
      m = longint'(record_id) + 1;
      rem = m % n;
      if (m <= n) cnt = m;
      else if (rem == 0) cnt = n;
      else if (sector_total == 1) cnt = rem;
      else begin
         lim  = (((slot + block) / sector_bytes) + 1) * sector_bytes;
         lost = (lim - region_base) / block;
         cnt  = (n + rem > lost + 1) ? n + rem - lost - 1 : 0;
      end
      if (cnt > 64'hFF_FFFF) cnt = 64'hFF_FFFF;
      page = 0;
      if (slot == region_base) begin
         r.erase_needed = 1'b1;
         page = slot;
      end else begin
         nxt = (slot / sector_bytes) * sector_bytes + sector_bytes;
         if (slot + block >= nxt) begin
            r.erase_needed = 1'b1;
            page = nxt;
         end
      end
      r.slot_address = slot[31:0];
      r.valid_count = cnt[23:0];
      r.erase_page_address = page[31:0];
      return r;
   endfunction

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function void note_request(logic [31:0] record_id);
      expected_q.push_back(map_id(record_id));
   endfunction

   task check_response(slot_map_type got);
      slot_map_type exp;
      if (expected_q.size() == 0) begin
         report("response with no request outstanding");
         return;
      end
      exp = expected_q.pop_front();
      if (got.slot_address !== exp.slot_address)
         report($sformatf("slot_address %h, expected %h", got.slot_address, exp.slot_address));
      if (got.valid_count !== exp.valid_count)
         report($sformatf("valid_count %0d, expected %0d", got.valid_count, exp.valid_count));
      if (got.erase_needed !== exp.erase_needed)
         report($sformatf("erase_needed %b, expected %b", got.erase_needed, exp.erase_needed));
      if (got.erase_page_address !== exp.erase_page_address)
         report($sformatf("erase_page_address %h, expected %h",
                          got.erase_page_address, exp.erase_page_address));
      if (got.id_unset !== exp.id_unset)
         report($sformatf("id_unset %b, expected %b", got.id_unset, exp.id_unset));
   endtask
endclass

module tb_flash_ring_slot_mapper_core;

   localparam int STALL_LIMIT = 5000;
   // An index beyond the register map.
   localparam logic [frsm_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [frsm_pkg::ID_W-1:0]      req_record_id;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [frsm_pkg::ADDR_W-1:0]    rsp_slot_address;
   logic [frsm_pkg::CNT_W-1:0]     rsp_valid_count;
   logic                           rsp_erase_needed;
   logic [frsm_pkg::ADDR_W-1:0]    rsp_erase_page_address;
   logic                           rsp_id_unset;
   logic                           csr_wr_en;
   logic [frsm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [frsm_pkg::ADDR_W-1:0]    csr_wdata;

   slot_map_scoreboard sb = new();
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   int  hold_cycles = 0;
   int  quiet_cycles = 0;

   flash_ring_slot_mapper_core u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: too long with neither channel moving means the block is stuck.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: checks accepted responses and chooses rsp_ready for the next cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_slot_address, rsp_valid_count, rsp_erase_needed,
                                rsp_erase_page_address, rsp_id_unset});
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_id(logic [31:0] record_id);
      req_valid <= 1'b1;
      req_record_id <= record_id;
      do @(posedge clock); while (!req_ready);
      sb.note_request(record_id);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] base, logic [31:0] sec, logic [31:0] tot,
                             logic [31:0] pay);
      logic [31:0] vals[4];
      logic [frsm_pkg::CSR_IDX_W-1:0] idx[4];
      vals = '{base, sec, tot, pay};
      idx  = '{frsm_pkg::CSR_REGION_BASE, frsm_pkg::CSR_SECTOR_BYTES,
               frsm_pkg::CSR_SECTOR_TOTAL, frsm_pkg::CSR_PAYLOAD_BYTES};
      req_valid <= 1'b0;
      wait_drained();
      repeat (5) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // An index outside the register map must be ignored.
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.region_base   = base;
      sb.sector_bytes  = sec[16:0];
      sb.sector_total  = tot[8:0];
      sb.payload_bytes = pay[9:0];
   endtask

   function automatic logic [31:0] pick_id();
      longint unsigned n;
      n = sb.slot_count();
      if (n == 0) n = 64;
      case ($urandom_range(9))
         0, 1, 2: return 32'($urandom_range(0, 32'(3 * n + 2)));
         3, 4:    return 32'($urandom_range(1, 200) * n + $urandom_range(0, 2) - 1);
         5:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] cfg[14][4];
      logic [31:0] directed[$];
      int n_items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_record_id = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      cfg[0]  = '{32'h0, 1024, 2, 26};
      cfg[1]  = '{32'hFFFF_FF00, 65536, 256, 1018};
      cfg[2]  = '{32'h0, 64, 1, 1};
      cfg[3]  = '{32'h1234_5670, 4096, 8, 58};
      cfg[4]  = '{32'h0000_1000, 1000, 3, 30};
      cfg[5]  = '{32'h0, 0, 2, 26};
      cfg[6]  = '{32'h5, 64, 0, 10};
      cfg[7]  = '{32'hFFFF_FFFF, 64, 1, 1018};
      cfg[8]  = '{32'hFFFF_FFFF, 131071, 511, 1023};
      cfg[9]  = '{32'h0, 64, 256, 1};
      for (int p = 10; p < 14; p++)
         cfg[p] = '{$urandom, $urandom_range(64, 65536), $urandom_range(1, 256),
                    $urandom_range(1, 1018)};

      // Reset settings first, with the edges of the id range and the wrap points.
      directed = '{0, 1, 62, 63, 64, 65, 127, 128, 129, 31, 32, 33,
                   32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFC0, 32'hFFFF_FFBF};
      foreach (directed[i]) send_id(directed[i]);

      for (int p = 0; p < 14; p++) begin
         write_regs(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
            1: begin sender_idle_pct = 69; receiver_idle_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_idle_pct = 69; end
            default: begin sender_idle_pct = 7; receiver_idle_pct = 7; end
         endcase
         if (p == 3) hold_cycles = 400;
         // The long hold needs more requests than the pipeline holds.
         n_items = (p == 0 || p == 1) ? 40 : (p == 3) ? 160 : 70;
         for (int i = 0; i < n_items; i++) begin
            if (p == 4 && i == n_items / 2) begin
               req_valid <= 1'b0;
               wait_drained();
               @(posedge clock);
            end
            send_id(pick_id());
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (120) @(posedge clock);
      if (sb.expected_q.size() != 0) sb.report("responses still outstanding at end of run");
      if (sb.mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/frsm_pkg.sv
hdl/frsm_div_pipe.sv
hdl/flash_ring_slot_mapper_core.sv
dv/tb_flash_ring_slot_mapper_core.sv
